/* design/u8s_pkg.sv */
package u8s_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [2:0] len_type;

   localparam int unsigned BufDepth = 4;

   localparam byte_type REPL_BYTE_0   = 8'hEF;
   localparam byte_type REPL_BYTE_1   = 8'hBF;
   localparam byte_type REPL_BYTE_2   = 8'hBD;
   localparam byte_type ASCII_MAX     = 8'h7F;
   localparam byte_type LEAD2_MIN     = 8'hC2;
   localparam byte_type LEAD2_MAX     = 8'hDF;
   localparam byte_type LEAD3_MIN     = 8'hE0;
   localparam byte_type LEAD3_MAX     = 8'hEF;
   localparam byte_type LEAD4_MIN     = 8'hF0;
   localparam byte_type LEAD4_MAX     = 8'hF4;
   localparam byte_type LEAD_SURR     = 8'hED;
   localparam byte_type CONT_MASK     = 8'hC0;
   localparam byte_type CONT_TAG      = 8'h80;
   localparam byte_type E0_SECOND_MIN = 8'hA0;
   localparam byte_type ED_SECOND_LIM = 8'hA0;
   localparam byte_type F0_SECOND_MIN = 8'h90;
   localparam byte_type F4_SECOND_LIM = 8'h90;

   localparam logic [1:0] REPL_LAST_IDX = 2'd2;

   typedef struct packed {
      logic load_data;
      logic load_flush;
      logic start;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic    stop;
      logic    group_end;
      logic    out_free;
      len_type held_n;
   } stat_type;

   function automatic len_type seq_len(byte_type lead);
      len_type len;
      len = 3'd0;
      if (lead <= ASCII_MAX) begin
         len = 3'd1;
      end else if (lead >= LEAD2_MIN && lead <= LEAD2_MAX) begin
         len = 3'd2;
      end else if (lead >= LEAD3_MIN && lead <= LEAD3_MAX) begin
         len = 3'd3;
      end else if (lead >= LEAD4_MIN && lead <= LEAD4_MAX) begin
         len = 3'd4;
      end
      return len;
   endfunction

   // True when a buffer starting with this lead and holding avail bytes yields output.
   function automatic logic yields_output(byte_type lead, len_type avail);
      len_type len;
      len = seq_len(lead);
      return (avail != 3'd0) && ((len == 3'd0) || (len <= avail));
   endfunction

endpackage

/* design/u8s_req_if.sv */
interface u8s_req_if;
   logic               valid;
   logic               ready;
   logic               req_type;
   u8s_pkg::byte_type  in_byte;

   modport source (output valid, output req_type, output in_byte, input ready);
   modport sink (input valid, input req_type, input in_byte, output ready);
endinterface

/* design/u8s_rsp_if.sv */
interface u8s_rsp_if;
   logic               valid;
   logic               ready;
   u8s_pkg::byte_type  out_byte;
   logic               last;

   modport source (output valid, output out_byte, output last, input ready);
   modport sink (input valid, input out_byte, input last, output ready);
endinterface

/* design/u8s_ctrl.sv */
module u8s_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_flush,
   output logic               req_ready,
   input  u8s_pkg::stat_type  stat,
   output u8s_pkg::cmd_type   cmd
);
   import u8s_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_flush) begin
                  if (stat.held_n != 3'd0) begin
                     cmd.load_flush = 1'b1;
                     state_in       = ST_EMIT;
                  end
               end else begin
                  cmd.load_data = 1'b1;
                  state_in      = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (stat.stop) begin
               state_in = ST_IDLE;
            end else begin
               cmd.start = 1'b1;
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               if (stat.group_end) begin
                  state_in = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* design/u8s_datapath.sv */
module u8s_datapath (
   input  logic               clock,
   input  logic               reset,
   input  u8s_pkg::byte_type  in_byte,
   input  u8s_pkg::cmd_type   cmd,
   output u8s_pkg::stat_type  stat,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output u8s_pkg::byte_type  rsp_byte,
   output logic               rsp_last
);
   import u8s_pkg::*;

   byte_type   buf_ff [BufDepth];
   len_type    n_ff;
   len_type    n_in;
   logic       repl_ff;
   logic [1:0] idx_ff;
   logic [1:0] rem_ff;
   logic       out_valid_ff;
   byte_type   out_byte_ff;
   logic       out_last_ff;

   len_type    len;
   logic       ok;
   logic       replace;
   logic       group_end;
   byte_type   emit_byte;
   len_type    avail_after;

   always_comb begin
      len = seq_len(buf_ff[0]);
      ok  = ((len < 3'd2) || ((buf_ff[1] & CONT_MASK) == CONT_TAG))
         && ((len < 3'd3) || ((buf_ff[2] & CONT_MASK) == CONT_TAG))
         && ((len < 3'd4) || ((buf_ff[3] & CONT_MASK) == CONT_TAG));
      if (len == 3'd3) begin
         if ((buf_ff[0] == LEAD3_MIN && buf_ff[1] < E0_SECOND_MIN)
             || (buf_ff[0] == LEAD_SURR && buf_ff[1] >= ED_SECOND_LIM)) begin
            ok = 1'b0;
         end
      end
      if (len == 3'd4) begin
         if ((buf_ff[0] == LEAD4_MIN && buf_ff[1] < F0_SECOND_MIN)
             || (buf_ff[0] == LEAD4_MAX && buf_ff[1] >= F4_SECOND_LIM)) begin
            ok = 1'b0;
         end
      end
      replace = (len == 3'd0) || !ok;

      group_end = repl_ff ? (idx_ff == REPL_LAST_IDX) : (rem_ff == 2'd0);
      emit_byte = buf_ff[0];
      if (repl_ff) begin
         case (idx_ff)
            2'd0:    emit_byte = REPL_BYTE_0;
            2'd1:    emit_byte = REPL_BYTE_1;
            default: emit_byte = REPL_BYTE_2;
         endcase
      end
      avail_after = n_ff - 3'd1;

      stat.stop      = (n_ff == 3'd0) || ((len != 3'd0) && (len > n_ff));
      stat.group_end = group_end;
      stat.out_free  = !out_valid_ff || rsp_ready;
      stat.held_n    = n_ff;

      n_in = n_ff;
      if (cmd.load_data) begin
         n_in = n_ff + 3'd1;
      end else if (cmd.load_flush) begin
         n_in = 3'd1;
      end else if (cmd.emit && group_end) begin
         n_in = avail_after;
      end else if (cmd.emit && !repl_ff) begin
         n_in = avail_after;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_data) begin
         buf_ff[n_ff[1:0]] <= in_byte;
      end else if (cmd.emit && (group_end || !repl_ff)) begin
         for (int i = 0; i < BufDepth - 1; i++) begin
            buf_ff[i] <= buf_ff[i + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff         <= 3'd0;
         repl_ff      <= 1'b0;
         idx_ff       <= 2'd0;
         rem_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         n_ff <= n_in;
         if (cmd.load_flush) begin
            repl_ff <= 1'b1;
            idx_ff  <= 2'd0;
         end else if (cmd.start) begin
            repl_ff <= replace;
            idx_ff  <= 2'd0;
            rem_ff  <= 2'(len - 3'd1);
         end else if (cmd.emit) begin
            if (repl_ff) begin
               idx_ff <= idx_ff + 2'd1;
            end else begin
               rem_ff <= rem_ff - 2'd1;
            end
         end
         if (cmd.emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_byte_ff <= emit_byte;
         out_last_ff <= group_end && !yields_output(buf_ff[1], avail_after);
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_byte  = out_byte_ff;
   assign rsp_last  = out_last_ff;

endmodule

/* design/utf8_stream_sanitizer.sv */
// Byte-stream UTF-8 sanitiser. Each transfer on the request channel carries one
// data byte (req_type low) or an end-of-stream flush (req_type high). Each
// transfer on the response channel carries one output byte; last marks the final
// byte caused by a request. Well-formed sequences pass through unchanged, and
// every rejected lead byte is replaced by EF BF BD.
// Sequencing: a data byte is accepted, then the held sequence is scanned; each
// output group is then emitted byte by byte, with a further scan after each
// group. A byte that completes nothing is only accepted and scanned. The
// scan-and-emit sequencer moves one byte a cycle through a single output
// register while the receiver takes them.
// The next request is taken while the last output byte still waits for its
// transfer. When the receiver stalls, the output register holds its byte and the
// sequencer waits; no request is taken until every pending byte has been emitted.
// Reset clears the pending sequence and the output register's valid flag.
module utf8_stream_sanitizer (
   input  logic       clock,
   input  logic       reset,
   u8s_req_if.sink    req_chan,
   u8s_rsp_if.source  rsp_chan
);
   import u8s_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     ready;

   u8s_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_flush (req_chan.req_type),
      .req_ready (ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   u8s_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .in_byte   (req_chan.in_byte),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_byte  (rsp_chan.out_byte),
      .rsp_last  (rsp_chan.last)
   );

   assign req_chan.ready = ready;

   assert property (@(posedge clock) disable iff (reset)
      ready |-> (stat.held_n <= 3'd3))
      else $error("pending sequence overflows the hold buffer");

   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && ready && !req_chan.req_type) |=> !ready)
      else $error("data byte accepted without a scan");

   assert property (@(posedge clock) disable iff (reset)
      cmd.load_flush |-> (stat.held_n != 3'd0))
      else $error("flush replacement with nothing pending");

   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> stat.out_free)
      else $error("output byte overwritten before its transfer");

endmodule
